/* rtl/core/pcfc_pkg.sv */
package pcfc_pkg;

    // EtherType values in host order
    localparam logic [15:0] ETH_TYPE_IPV4 = 16'h0800;
    localparam logic [15:0] ETH_TYPE_ARP  = 16'h0806;

    localparam int unsigned NUM_SLOTS = 4;

    // frame class codes
    localparam logic [2:0] CLASS_SLOT0   = 3'd0;
    localparam logic [2:0] CLASS_SLOT1   = 3'd1;
    localparam logic [2:0] CLASS_SLOT2   = 3'd2;
    localparam logic [2:0] CLASS_SLOT3   = 3'd3;
    localparam logic [2:0] CLASS_OTHER   = 3'd4;
    localparam logic [2:0] CLASS_ARP     = 3'd5;
    localparam logic [2:0] CLASS_NON_IP  = 3'd6;
    localparam logic [2:0] CLASS_DROPPED = 3'd7;

    // configuration register indexes
    localparam logic [2:0] REG_ADDR_FILTER_ON = 3'd0;
    localparam logic [2:0] REG_FILTER_ADDRESS = 3'd1;
    localparam logic [2:0] REG_SLOT0_PROTOCOL = 3'd2;
    localparam logic [2:0] REG_SLOT1_PROTOCOL = 3'd3;
    localparam logic [2:0] REG_SLOT2_PROTOCOL = 3'd4;
    localparam logic [2:0] REG_SLOT3_PROTOCOL = 3'd5;

    // slot protocol reset values: ICMP, IGMP, TCP, UDP
    localparam logic [7:0] SLOT0_RESET = 8'd1;
    localparam logic [7:0] SLOT1_RESET = 8'd2;
    localparam logic [7:0] SLOT2_RESET = 8'd6;
    localparam logic [7:0] SLOT3_RESET = 8'd17;

    typedef struct packed {
        logic [15:0] ether_type;
        logic [31:0] src_address;
        logic [31:0] dst_address;
        logic [7:0]  proto_number;
    } hdr_item_t;

    typedef struct packed {
        logic [2:0]  frame_class;
        logic [31:0] slot0_tally;
        logic [31:0] slot1_tally;
        logic [31:0] slot2_tally;
        logic [31:0] slot3_tally;
        logic [31:0] arp_tally;
        logic [31:0] other_tally;
        logic [31:0] frame_tally;
    } res_item_t;

    typedef struct packed {
        logic                           addr_filter_on;
        logic [31:0]                    filter_address;
        logic [NUM_SLOTS-1:0][7:0]      slot_protocol;
    } cfg_t;

    // classifier verdict: class code plus counter bump enables
    typedef struct packed {
        logic [2:0]           frame_class;
        logic [NUM_SLOTS-1:0] slot_inc;
        logic                 arp_inc;
        logic                 other_inc;
    } verdict_t;

    typedef struct packed {
        logic [NUM_SLOTS-1:0][31:0] slot_count;
        logic [31:0]                arp_count;
        logic [31:0]                other_count;
        logic [31:0]                frame_count;
    } tally_t;

endpackage

/* rtl/core/pcfc_classify.sv */
module pcfc_classify (
    input  pcfc_pkg::hdr_item_t hdr,
    input  pcfc_pkg::cfg_t      cfg,
    output pcfc_pkg::verdict_t  verdict
);

    logic                           is_ipv4;
    logic                           is_arp;
    logic                           addr_drop;
    logic [pcfc_pkg::NUM_SLOTS-1:0] slot_hit;

    assign is_ipv4   = (hdr.ether_type == pcfc_pkg::ETH_TYPE_IPV4);
    assign is_arp    = (hdr.ether_type == pcfc_pkg::ETH_TYPE_ARP);
    assign addr_drop = cfg.addr_filter_on
                     && (hdr.src_address != cfg.filter_address)
                     && (hdr.dst_address != cfg.filter_address);

    always_comb
    begin
        for (int k = 0; k < pcfc_pkg::NUM_SLOTS; k++)
        begin
            slot_hit[k] = (hdr.proto_number == cfg.slot_protocol[k]);
        end
    end

    // lowest slot wins
    always_comb
    begin
        verdict = '0;
        if (is_ipv4)
        begin
            if (addr_drop)
            begin
                verdict.frame_class = pcfc_pkg::CLASS_DROPPED;
            end
            else if (slot_hit[0])
            begin
                verdict.frame_class = pcfc_pkg::CLASS_SLOT0;
                verdict.slot_inc[0] = 1'b1;
            end
            else if (slot_hit[1])
            begin
                verdict.frame_class = pcfc_pkg::CLASS_SLOT1;
                verdict.slot_inc[1] = 1'b1;
            end
            else if (slot_hit[2])
            begin
                verdict.frame_class = pcfc_pkg::CLASS_SLOT2;
                verdict.slot_inc[2] = 1'b1;
            end
            else if (slot_hit[3])
            begin
                verdict.frame_class = pcfc_pkg::CLASS_SLOT3;
                verdict.slot_inc[3] = 1'b1;
            end
            else
            begin
                verdict.frame_class = pcfc_pkg::CLASS_OTHER;
                verdict.other_inc   = 1'b1;
            end
        end
        else if (is_arp)
        begin
            verdict.frame_class = pcfc_pkg::CLASS_ARP;
            verdict.arp_inc     = 1'b1;
        end
        else
        begin
            verdict.frame_class = pcfc_pkg::CLASS_NON_IP;
        end
    end

endmodule

/* rtl/core/pcfc_counters.sv */
module pcfc_counters (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               advance,
    input  pcfc_pkg::verdict_t verdict,
    output pcfc_pkg::tally_t   tally
);

    pcfc_pkg::tally_t tally_reg;
    pcfc_pkg::tally_t tally_next;

    always_comb
    begin
        tally_next = tally_reg;
        if (advance)
        begin
            for (int k = 0; k < pcfc_pkg::NUM_SLOTS; k++)
            begin
                if (verdict.slot_inc[k])
                begin
                    tally_next.slot_count[k] = tally_reg.slot_count[k] + 32'd1;
                end
            end
            if (verdict.arp_inc)
            begin
                tally_next.arp_count = tally_reg.arp_count + 32'd1;
            end
            if (verdict.other_inc)
            begin
                tally_next.other_count = tally_reg.other_count + 32'd1;
            end
            tally_next.frame_count = tally_reg.frame_count + 32'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tally_reg <= '0;
        end
        else
        begin
            tally_reg <= tally_next;
        end
    end

    assign tally = tally_reg;

endmodule

/* rtl/core/packet_class_filter_counter.sv */
// Frame classifier with per-class counters.
//
// Header channel (hdr_valid / hdr_stall / hdr): one header summary per
// transfer. Result channel (res_valid / res_stall / res): one result per
// header, carrying the class code and every counter after that frame.
// Configuration is a plain write port (cfg_we / cfg_index / cfg_wdata); the
// user must write it only while no frame is in flight; the block does not enforce this.
//
// A header that is taken sits in the input register, then moves into the
// result register, from which it can transfer out. Throughput: one frame per
// cycle while res_stall does not block the result; the classify compares and
// the 32-bit increments sit in one register stage.
//
// The counters themselves are the result payload: they step only when a
// frame moves into the result register, so a stalled result holds still.
// When res_stall is high with a result pending, the input register holds
// its frame and hdr_stall rises once that register is occupied.
//
// Reset clears all counters and valid flags, the filter to off/0.0.0.0,
// and the slot protocols to 1, 2, 6 and 17.
module packet_class_filter_counter (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                hdr_valid,
    output logic                hdr_stall,
    input  pcfc_pkg::hdr_item_t hdr,
    output logic                res_valid,
    input  logic                res_stall,
    output pcfc_pkg::res_item_t res,
    input  logic                cfg_we,
    input  logic [2:0]          cfg_index,
    input  logic [31:0]         cfg_wdata
);

    // configuration
    pcfc_pkg::cfg_t cfg_reg;

    // input stage
    logic                s1_valid_reg;
    pcfc_pkg::hdr_item_t s1_item_reg;

    // result stage
    logic       res_valid_reg;
    logic [2:0] class_reg;

    logic               res_blocked;
    logic               s1_advance;
    logic               hdr_xfer;
    pcfc_pkg::verdict_t verdict;
    pcfc_pkg::tally_t   tally;

    assign res_blocked = res_valid_reg && res_stall;
    assign s1_advance  = s1_valid_reg && !res_blocked;
    assign hdr_stall   = s1_valid_reg && res_blocked;
    assign hdr_xfer    = hdr_valid && !hdr_stall;

    // config writes; unknown indexes fall through
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.addr_filter_on   <= 1'b0;
            cfg_reg.filter_address   <= '0;
            cfg_reg.slot_protocol[0] <= pcfc_pkg::SLOT0_RESET;
            cfg_reg.slot_protocol[1] <= pcfc_pkg::SLOT1_RESET;
            cfg_reg.slot_protocol[2] <= pcfc_pkg::SLOT2_RESET;
            cfg_reg.slot_protocol[3] <= pcfc_pkg::SLOT3_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                pcfc_pkg::REG_ADDR_FILTER_ON: cfg_reg.addr_filter_on   <= cfg_wdata[0];
                pcfc_pkg::REG_FILTER_ADDRESS: cfg_reg.filter_address   <= cfg_wdata;
                pcfc_pkg::REG_SLOT0_PROTOCOL: cfg_reg.slot_protocol[0] <= cfg_wdata[7:0];
                pcfc_pkg::REG_SLOT1_PROTOCOL: cfg_reg.slot_protocol[1] <= cfg_wdata[7:0];
                pcfc_pkg::REG_SLOT2_PROTOCOL: cfg_reg.slot_protocol[2] <= cfg_wdata[7:0];
                pcfc_pkg::REG_SLOT3_PROTOCOL: cfg_reg.slot_protocol[3] <= cfg_wdata[7:0];
                default:
                begin
                end
            endcase
        end
    end

    // valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (!s1_valid_reg || !res_blocked)
            begin
                s1_valid_reg <= hdr_valid;
            end
            if (!res_blocked)
            begin
                res_valid_reg <= s1_valid_reg;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (hdr_xfer)
        begin
            s1_item_reg <= hdr;
        end
        if (s1_advance)
        begin
            class_reg <= verdict.frame_class;
        end
    end

    pcfc_classify u_classify (
        .hdr     (s1_item_reg),
        .cfg     (cfg_reg),
        .verdict (verdict)
    );

    pcfc_counters u_counters (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (s1_advance),
        .verdict (verdict),
        .tally   (tally)
    );

    assign res_valid       = res_valid_reg;
    assign res.frame_class = class_reg;
    assign res.slot0_tally = tally.slot_count[0];
    assign res.slot1_tally = tally.slot_count[1];
    assign res.slot2_tally = tally.slot_count[2];
    assign res.slot3_tally = tally.slot_count[3];
    assign res.arp_tally   = tally.arp_count;
    assign res.other_tally = tally.other_count;
    assign res.frame_tally = tally.frame_count;

endmodule

/* rtl/core/pcfc_checker.sv */
module pcfc_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                hdr_stall,
    input logic                res_valid,
    input logic                res_stall,
    input pcfc_pkg::res_item_t res
);

    // held result must not move
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid && $stable(res))
        else $error("result changed while stalled");

    // input back-pressure only comes from a blocked result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        hdr_stall |-> res_valid && res_stall)
        else $error("header stalled without a blocked result");

    // frame count steps by at most one per cycle
    a_frame_step: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(res.frame_tally) |->
            res.frame_tally == $past(res.frame_tally) + 32'd1)
        else $error("frame tally jumped");

    // a new count always comes with a valid result
    a_step_valid: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(res.frame_tally) |-> res_valid)
        else $error("frame tally moved without a result");

    // class counters only move together with the frame count
    a_class_tied: assert property (@(posedge clk) disable iff (!rst_n)
        $stable(res.frame_tally) |->
            $stable(res.slot0_tally) && $stable(res.slot1_tally)
            && $stable(res.slot2_tally) && $stable(res.slot3_tally)
            && $stable(res.arp_tally) && $stable(res.other_tally))
        else $error("class tally moved without a frame");

endmodule

bind packet_class_filter_counter pcfc_checker u_pcfc_checker (.*);

/* verif/class_tally_checker.sv */
`timescale 1ns / 1ps

// Watches the header, result and register ports of the classifier, keeps a
// shadow of its registers and counters, and compares every result transfer
// against the oldest frame still owed a result.
module class_tally_checker (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                hdr_valid,
    input  logic                hdr_stall,
    input  pcfc_pkg::hdr_item_t hdr,
    input  logic                res_valid,
    input  logic                res_stall,
    input  pcfc_pkg::res_item_t res,
    input  logic                cfg_we,
    input  logic [2:0]          cfg_index,
    input  logic [31:0]         cfg_wdata,
    output int                  mismatch_count,
    output int                  owed_count
);

    pcfc_pkg::cfg_t      regs;
    pcfc_pkg::tally_t    tallies;
    pcfc_pkg::res_item_t owed_results[$];
    int                  misses;

    function automatic void clear_shadow();
        regs.addr_filter_on   = 1'b0;
        regs.filter_address   = '0;
        regs.slot_protocol[0] = pcfc_pkg::SLOT0_RESET;
        regs.slot_protocol[1] = pcfc_pkg::SLOT1_RESET;
        regs.slot_protocol[2] = pcfc_pkg::SLOT2_RESET;
        regs.slot_protocol[3] = pcfc_pkg::SLOT3_RESET;
        tallies               = '0;
    endfunction

    // unknown indexes fall through; upper data bits are dropped
    function automatic void shadow_write(logic [2:0] idx, logic [31:0] data);
        case (idx)
            pcfc_pkg::REG_ADDR_FILTER_ON: regs.addr_filter_on   = data[0];
            pcfc_pkg::REG_FILTER_ADDRESS: regs.filter_address   = data;
            pcfc_pkg::REG_SLOT0_PROTOCOL: regs.slot_protocol[0] = data[7:0];
            pcfc_pkg::REG_SLOT1_PROTOCOL: regs.slot_protocol[1] = data[7:0];
            pcfc_pkg::REG_SLOT2_PROTOCOL: regs.slot_protocol[2] = data[7:0];
            pcfc_pkg::REG_SLOT3_PROTOCOL: regs.slot_protocol[3] = data[7:0];
            default: ;
        endcase
    endfunction

    function automatic pcfc_pkg::res_item_t classify_and_count(pcfc_pkg::hdr_item_t f);
        pcfc_pkg::res_item_t r;
        logic [2:0]          cls;
        logic                hit;
        tallies.frame_count = tallies.frame_count + 32'd1;
        if (f.ether_type == pcfc_pkg::ETH_TYPE_IPV4)
        begin
            if (regs.addr_filter_on && f.src_address != regs.filter_address
                && f.dst_address != regs.filter_address)
            begin
                cls = pcfc_pkg::CLASS_DROPPED;
            end
            else
            begin
                // lowest slot wins on duplicate protocol values
                cls = pcfc_pkg::CLASS_OTHER;
                hit = 1'b0;
                for (int k = 0; k < pcfc_pkg::NUM_SLOTS; k++)
                begin
                    if (!hit && f.proto_number == regs.slot_protocol[k])
                    begin
                        tallies.slot_count[k] = tallies.slot_count[k] + 32'd1;
                        cls = 3'(k);
                        hit = 1'b1;
                    end
                end
                if (!hit)
                begin
                    tallies.other_count = tallies.other_count + 32'd1;
                end
            end
        end
        else if (f.ether_type == pcfc_pkg::ETH_TYPE_ARP)
        begin
            tallies.arp_count = tallies.arp_count + 32'd1;
            cls = pcfc_pkg::CLASS_ARP;
        end
        else
        begin
            cls = pcfc_pkg::CLASS_NON_IP;
        end
        r.frame_class = cls;
        r.slot0_tally = tallies.slot_count[0];
        r.slot1_tally = tallies.slot_count[1];
        r.slot2_tally = tallies.slot_count[2];
        r.slot3_tally = tallies.slot_count[3];
        r.arp_tally   = tallies.arp_count;
        r.other_tally = tallies.other_count;
        r.frame_tally = tallies.frame_count;
        return r;
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            misses++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        pcfc_pkg::res_item_t want;
        if (!rst_n)
        begin
            clear_shadow();
            owed_results.delete();
            misses = 0;
            mismatch_count <= 0;
            owed_count     <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                shadow_write(cfg_index, cfg_wdata);
            end
            if (hdr_valid && !hdr_stall)
            begin
                owed_results.push_back(classify_and_count(hdr));
            end
            if (res_valid && !res_stall)
            begin
                if (owed_results.size() == 0)
                begin
                    $error("result transfer with no frame owed: class %0d", res.frame_class);
                    misses++;
                end
                else
                begin
                    want = owed_results.pop_front();
                    check_field("frame_class", 32'(want.frame_class), 32'(res.frame_class));
                    check_field("slot0_tally", want.slot0_tally, res.slot0_tally);
                    check_field("slot1_tally", want.slot1_tally, res.slot1_tally);
                    check_field("slot2_tally", want.slot2_tally, res.slot2_tally);
                    check_field("slot3_tally", want.slot3_tally, res.slot3_tally);
                    check_field("arp_tally", want.arp_tally, res.arp_tally);
                    check_field("other_tally", want.other_tally, res.other_tally);
                    check_field("frame_tally", want.frame_tally, res.frame_tally);
                end
            end
            mismatch_count <= misses;
            owed_count     <= owed_results.size();
        end
    end

endmodule

/* verif/tb_packet_class_filter_counter.sv */
`timescale 1ns / 1ps

module tb_packet_class_filter_counter;

    // Worst case is roughly 450 frames, each with a long send gap and a long stall,
    // plus register phases; the limit sits several times above that.
    localparam int CYCLE_LIMIT = 400000;

    // register indexes the block does not decode; writes there must be no-ops
    localparam logic [2:0] REG_SPARE_LO = 3'd6;
    localparam logic [2:0] REG_SPARE_HI = 3'd7;

    localparam int RANDOM_PHASES    = 8;
    localparam int FRAMES_PER_PHASE = 50;

    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                hdr_valid = 1'b0;
    logic                hdr_stall;
    pcfc_pkg::hdr_item_t hdr       = '0;
    logic                res_valid;
    logic                res_stall = 1'b0;
    pcfc_pkg::res_item_t res;
    logic                cfg_we    = 1'b0;
    logic [2:0]          cfg_index = '0;
    logic [31:0]         cfg_wdata = '0;

    int mismatch_count;
    int owed_count;
    int cycle_count = 0;
    int frames_sent = 0;
    int settings_applied = 0;
    int stall_hold = 0;

    // stimulus-side copy of the current register values, used only to aim
    // frames at slot hits and filter matches
    logic [31:0] cur_filter_addr;
    logic [7:0]  cur_slots [pcfc_pkg::NUM_SLOTS];

    packet_class_filter_counter uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .hdr_valid (hdr_valid),
        .hdr_stall (hdr_stall),
        .hdr       (hdr),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    class_tally_checker checker_i (
        .clk            (clk),
        .rst_n          (rst_n),
        .hdr_valid      (hdr_valid),
        .hdr_stall      (hdr_stall),
        .hdr            (hdr),
        .res_valid      (res_valid),
        .res_stall      (res_stall),
        .res            (res),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .mismatch_count (mismatch_count),
        .owed_count     (owed_count)
    );

    always #5 clk = ~clk;

    // Watchdog: a hung handshake ends the run here.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles with %0d results owed", cycle_count, owed_count);
            $display("FAILED: results differ");
            $finish;
        end
    end

    // Idle length: mostly short, now and then long.
    function automatic int pick_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
        begin
            return $urandom_range(1, 3);
        end
        else if (r < 93)
        begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    // Receiver back-pressure: alternating stall / run stretches; some run
    // stretches are long so the pipe also gets exercised at full rate.
    always @(posedge clk)
    begin
        if (stall_hold > 0)
        begin
            stall_hold <= stall_hold - 1;
        end
        else if (res_stall)
        begin
            res_stall  <= 1'b0;
            stall_hold <= ($urandom_range(0, 99) < 10) ? $urandom_range(50, 150)
                                                      : $urandom_range(0, 5);
        end
        else
        begin
            res_stall  <= 1'b1;
            stall_hold <= pick_len() - 1;
        end
    end

    // One header transfer. Valid stays high across back-to-back frames; it is
    // only lowered when a gap is inserted.
    task automatic send_frame(input logic [15:0] et, input logic [31:0] sa,
                              input logic [31:0] da, input logic [7:0] pn);
        pcfc_pkg::hdr_item_t f;
        int                  gap;
        f.ether_type   = et;
        f.src_address  = sa;
        f.dst_address  = da;
        f.proto_number = pn;
        gap = ($urandom_range(0, 99) < 55) ? 0 : pick_len();
        if (gap > 0)
        begin
            hdr_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        hdr_valid <= 1'b1;
        hdr       <= f;
        @(posedge clk);
        while (hdr_stall) @(posedge clk);
        frames_sent++;
    endtask

    task automatic send_random_frame();
        logic [31:0] raw;
        logic [15:0] et;
        logic [31:0] sa;
        logic [31:0] da;
        logic [7:0]  pn;
        int          r;
        raw = $urandom();
        r   = $urandom_range(0, 99);
        if (r < 50)
        begin
            et = pcfc_pkg::ETH_TYPE_IPV4;
        end
        else if (r < 70)
        begin
            et = pcfc_pkg::ETH_TYPE_ARP;
        end
        else
        begin
            et = raw[15:0];
        end
        sa = $urandom();
        da = $urandom();
        r  = $urandom_range(0, 99);
        if (r < 25)
        begin
            sa = cur_filter_addr;
        end
        else if (r < 50)
        begin
            da = cur_filter_addr;
        end
        else if (r < 60)
        begin
            sa = cur_filter_addr;
            da = cur_filter_addr;
        end
        if ($urandom_range(0, 99) < 60)
        begin
            pn = cur_slots[$urandom_range(0, pcfc_pkg::NUM_SLOTS - 1)];
        end
        else
        begin
            pn = 8'($urandom_range(0, 255));
        end
        send_frame(et, sa, da, pn);
    endtask

    // Let the pipe drain before touching registers. The first edge lets the
    // checker's owed count catch up with the last transfer.
    task automatic drain();
        hdr_valid <= 1'b0;
        @(posedge clk);
        while (owed_count != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Leaves cfg_we high; apply_settings lowers it once after the last write.
    task automatic put_reg(input logic [2:0] idx, input logic [31:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge clk);
    endtask

    // Writes every register with junk in the unused upper bits, plus the two
    // undecoded indexes, which must not disturb anything.
    task automatic apply_settings(input logic on, input logic [31:0] addr,
                                  input logic [7:0] s0, input logic [7:0] s1,
                                  input logic [7:0] s2, input logic [7:0] s3);
        logic [31:0] junk;
        junk = $urandom();
        junk[0] = on;
        put_reg(pcfc_pkg::REG_ADDR_FILTER_ON, junk);
        put_reg(REG_SPARE_LO, $urandom());
        put_reg(pcfc_pkg::REG_FILTER_ADDRESS, addr);
        junk = $urandom();
        junk[7:0] = s0;
        put_reg(pcfc_pkg::REG_SLOT0_PROTOCOL, junk);
        junk = $urandom();
        junk[7:0] = s1;
        put_reg(pcfc_pkg::REG_SLOT1_PROTOCOL, junk);
        junk = $urandom();
        junk[7:0] = s2;
        put_reg(pcfc_pkg::REG_SLOT2_PROTOCOL, junk);
        junk = $urandom();
        junk[7:0] = s3;
        put_reg(pcfc_pkg::REG_SLOT3_PROTOCOL, junk);
        put_reg(REG_SPARE_HI, $urandom());
        cfg_we <= 1'b0;
        cur_filter_addr = addr;
        cur_slots[0]    = s0;
        cur_slots[1]    = s1;
        cur_slots[2]    = s2;
        cur_slots[3]    = s3;
        settings_applied++;
    endtask

    function automatic logic [7:0] pick_slot_value(logic [7:0] prev);
        int r;
        r = $urandom_range(0, 99);
        if (r < 25)
        begin
            return prev;            // duplicate of the slot above it
        end
        else if (r < 35)
        begin
            return 8'h00;
        end
        else if (r < 45)
        begin
            return 8'hFF;
        end
        return 8'($urandom_range(0, 255));
    endfunction

    initial
    begin
        logic [31:0] addr;
        logic [7:0]  s0;
        logic [7:0]  s1;
        logic [7:0]  s2;
        logic [7:0]  s3;
        int          r;

        cur_filter_addr = '0;
        cur_slots[0]    = pcfc_pkg::SLOT0_RESET;
        cur_slots[1]    = pcfc_pkg::SLOT1_RESET;
        cur_slots[2]    = pcfc_pkg::SLOT2_RESET;
        cur_slots[3]    = pcfc_pkg::SLOT3_RESET;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset register values: each default slot, other IPv4, ARP, non-IP
        send_frame(pcfc_pkg::ETH_TYPE_IPV4, 32'h0000_0000, 32'hFFFF_FFFF,
                   pcfc_pkg::SLOT0_RESET);
        send_frame(pcfc_pkg::ETH_TYPE_IPV4, 32'hFFFF_FFFF, 32'h0000_0000,
                   pcfc_pkg::SLOT1_RESET);
        send_frame(pcfc_pkg::ETH_TYPE_IPV4, 32'h0A00_0001, 32'h0A00_0002,
                   pcfc_pkg::SLOT2_RESET);
        send_frame(pcfc_pkg::ETH_TYPE_IPV4, 32'h0A00_0001, 32'h0A00_0002,
                   pcfc_pkg::SLOT3_RESET);
        send_frame(pcfc_pkg::ETH_TYPE_IPV4, 32'h0000_0000, 32'h0000_0000, 8'h00);
        send_frame(pcfc_pkg::ETH_TYPE_IPV4, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF);
        send_frame(pcfc_pkg::ETH_TYPE_ARP, 32'h0000_0000, 32'h0000_0000, 8'h00);
        send_frame(pcfc_pkg::ETH_TYPE_ARP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF);
        send_frame(16'h0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, pcfc_pkg::SLOT2_RESET);
        send_frame(16'hFFFF, 32'h0000_0000, 32'h0000_0000, pcfc_pkg::SLOT3_RESET);
        send_frame(16'h0801, 32'h1234_5678, 32'h9ABC_DEF0, pcfc_pkg::SLOT0_RESET);
        send_frame(16'h0807, 32'h1234_5678, 32'h9ABC_DEF0, 8'h11);
        send_frame(16'h86DD, 32'h1234_5678, 32'h9ABC_DEF0, 8'h06);
        drain();

        // filter on: source hit, destination hit, both, neither; ARP and
        // non-IP frames bypass the filter
        apply_settings(1'b1, 32'hC0A8_0001, pcfc_pkg::SLOT0_RESET, pcfc_pkg::SLOT1_RESET,
                       pcfc_pkg::SLOT2_RESET, pcfc_pkg::SLOT3_RESET);
        send_frame(pcfc_pkg::ETH_TYPE_IPV4, 32'hC0A8_0001, 32'h0808_0808,
                   pcfc_pkg::SLOT2_RESET);
        send_frame(pcfc_pkg::ETH_TYPE_IPV4, 32'h0808_0808, 32'hC0A8_0001,
                   pcfc_pkg::SLOT3_RESET);
        send_frame(pcfc_pkg::ETH_TYPE_IPV4, 32'hC0A8_0001, 32'hC0A8_0001, 8'hC8);
        send_frame(pcfc_pkg::ETH_TYPE_IPV4, 32'hC0A8_0002, 32'h3FA8_0001,
                   pcfc_pkg::SLOT2_RESET);
        send_frame(pcfc_pkg::ETH_TYPE_IPV4, 32'h0000_0000, 32'hFFFF_FFFF, 8'hC8);
        send_frame(pcfc_pkg::ETH_TYPE_ARP, 32'h0000_0001, 32'h0000_0002, 8'h01);
        send_frame(16'h8100, 32'h0000_0001, 32'h0000_0002, 8'h01);
        drain();

        // duplicate slot values: the lowest slot must win
        apply_settings(1'b0, 32'hFFFF_FFFF, 8'h55, 8'h55, 8'h00, 8'hFF);
        send_frame(pcfc_pkg::ETH_TYPE_IPV4, 32'hDEAD_BEEF, 32'h0BAD_F00D, 8'h55);
        send_frame(pcfc_pkg::ETH_TYPE_IPV4, 32'hDEAD_BEEF, 32'h0BAD_F00D, 8'h00);
        send_frame(pcfc_pkg::ETH_TYPE_IPV4, 32'hDEAD_BEEF, 32'h0BAD_F00D, 8'hFF);
        send_frame(pcfc_pkg::ETH_TYPE_IPV4, 32'hDEAD_BEEF, 32'h0BAD_F00D, 8'h54);
        drain();

        // random phases: new register settings each time, filter extremes
        // forced into the last two
        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            r = $urandom_range(0, 99);
            if (ph == RANDOM_PHASES - 1 || r < 15)
            begin
                addr = 32'hFFFF_FFFF;
            end
            else if (ph == RANDOM_PHASES - 2 || r < 30)
            begin
                addr = 32'h0000_0000;
            end
            else
            begin
                addr = $urandom();
            end
            s0 = pick_slot_value(8'($urandom_range(0, 255)));
            s1 = pick_slot_value(s0);
            s2 = pick_slot_value(s1);
            s3 = pick_slot_value(s2);
            apply_settings((ph >= RANDOM_PHASES - 2) ? 1'b1 : 1'($urandom_range(0, 1)),
                           addr, s0, s1, s2, s3);
            repeat (FRAMES_PER_PHASE) send_random_frame();
            drain();
        end

        // back to the reset values, written explicitly this time
        apply_settings(1'b0, 32'h0000_0000, pcfc_pkg::SLOT0_RESET, pcfc_pkg::SLOT1_RESET,
                       pcfc_pkg::SLOT2_RESET, pcfc_pkg::SLOT3_RESET);
        repeat (12) send_random_frame();

        drain();
        repeat (8) @(posedge clk);

        $display("Sent %0d frames over %0d register settings: filter on/off, hits on",
                 frames_sent, settings_applied);
        $display("source/destination, duplicate and extreme slots, ARP and non-IP types");
        if (mismatch_count == 0 && owed_count == 0)
        begin
            $display("PASSED: all results match");
        end
        else
        begin
            $display("%0d mismatches, %0d results still owed", mismatch_count, owed_count);
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

/* sim.f */
rtl/core/pcfc_pkg.sv
rtl/core/pcfc_classify.sv
rtl/core/pcfc_counters.sv
rtl/core/packet_class_filter_counter.sv
rtl/core/pcfc_checker.sv
verif/class_tally_checker.sv
verif/tb_packet_class_filter_counter.sv
